// ===== design/bvot_pkg.sv =====
// ----------------------------------------------------------------------------
// bvot_pkg: shared constants for the bounding volume overlap test
// Coordinate widths, derived datapath widths and operation codes.
// ----------------------------------------------------------------------------
package bvot_pkg;

  // Signed coordinate width (Q16.16 at 32)
  localparam int COORD_W = 32;
  // Sizes and radii are one bit narrower, unsigned
  localparam int SIZE_W  = COORD_W - 1;
  // Doubled coordinate plus or minus a size, signed
  localparam int EXT_W   = COORD_W + 2;
  // Per-axis distance in doubled units, unsigned
  localparam int GAP_W   = COORD_W + 2;
  // Center difference, signed
  localparam int DIFF_W  = COORD_W + 1;
  // Comparison limit (2*radius or sum of radii), unsigned
  localparam int LIM_W   = COORD_W;

  // Split of the distance for squaring by partial products
  localparam int DLO_W   = GAP_W / 2;
  localparam int DHI_W   = GAP_W - DLO_W;
  localparam int SQ_W    = 2 * GAP_W;

  // Split of the limit for squaring
  localparam int LLO_W   = LIM_W / 2;
  localparam int LHI_W   = LIM_W - LLO_W;
  localparam int LSQ_W   = 2 * LIM_W;

  // Sum of three squares
  localparam int SUM_W   = SQ_W + 2;

  // Operation codes
  localparam logic [1:0] OP_BOX_POINT     = 2'd0;
  localparam logic [1:0] OP_BOX_SPHERE    = 2'd1;
  localparam logic [1:0] OP_SPHERE_SPHERE = 2'd2;

  localparam int AXES = 3;

endpackage

// ===== design/bounding_volume_overlap_test.sv =====
// ----------------------------------------------------------------------------
// bounding_volume_overlap_test
// Six-stage pipelined overlap test: box/point, box/sphere, sphere/sphere.
// ----------------------------------------------------------------------------
//
//  channel   | handshake              | payload
//  ----------+------------------------+--------------------------------------
//  request   | req_valid / req_stall  | operation, a_center_*, a_extent_*,
//            |                        | a_radius, b_center_*, b_radius
//  result    | res_valid / res_stall  | hit
//
//  One request per cycle while no result is stalled; hit passes the stage
//  registers s1 to s6 and is valid together with res_valid.
//  Stages: box bounds, clamp distance, 17x17 and 16x16 partial products, square
//  assembly, three-way sum and final compare.
//  rst (synchronous, active high) clears all stage valid bits.
//  A stalled result freezes the whole pipeline; req_stall is raised in
//  the same cycle, so nothing is dropped or repeated.
//
module bounding_volume_overlap_test (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  req_valid,
  output logic                                  req_stall,
  input  logic [1:0]                            operation,
  input  logic signed [bvot_pkg::COORD_W-1:0]   a_center_x,
  input  logic signed [bvot_pkg::COORD_W-1:0]   a_center_y,
  input  logic signed [bvot_pkg::COORD_W-1:0]   a_center_z,
  input  logic [bvot_pkg::SIZE_W-1:0]           a_extent_x,
  input  logic [bvot_pkg::SIZE_W-1:0]           a_extent_y,
  input  logic [bvot_pkg::SIZE_W-1:0]           a_extent_z,
  input  logic [bvot_pkg::SIZE_W-1:0]           a_radius,
  input  logic signed [bvot_pkg::COORD_W-1:0]   b_center_x,
  input  logic signed [bvot_pkg::COORD_W-1:0]   b_center_y,
  input  logic signed [bvot_pkg::COORD_W-1:0]   b_center_z,
  input  logic [bvot_pkg::SIZE_W-1:0]           b_radius,
  output logic                                  res_valid,
  input  logic                                  res_stall,
  output logic                                  hit
);

  localparam int COORD_W = bvot_pkg::COORD_W;
  localparam int SIZE_W  = bvot_pkg::SIZE_W;
  localparam int EXT_W   = bvot_pkg::EXT_W;
  localparam int GAP_W   = bvot_pkg::GAP_W;
  localparam int DIFF_W  = bvot_pkg::DIFF_W;
  localparam int LIM_W   = bvot_pkg::LIM_W;
  localparam int DLO_W   = bvot_pkg::DLO_W;
  localparam int DHI_W   = bvot_pkg::DHI_W;
  localparam int SQ_W    = bvot_pkg::SQ_W;
  localparam int LLO_W   = bvot_pkg::LLO_W;
  localparam int LHI_W   = bvot_pkg::LHI_W;
  localparam int LSQ_W   = bvot_pkg::LSQ_W;
  localparam int SUM_W   = bvot_pkg::SUM_W;
  localparam int AXES    = bvot_pkg::AXES;

  // Pipeline advance: freeze everything while a result waits
  logic adv;
  assign adv       = !(res_valid && res_stall);
  assign req_stall = !adv;

  // Per-axis views of the request
  logic signed [COORD_W-1:0] ac [AXES];
  logic signed [COORD_W-1:0] bc [AXES];
  logic [SIZE_W-1:0]         ae [AXES];

  assign ac[0] = a_center_x;
  assign ac[1] = a_center_y;
  assign ac[2] = a_center_z;
  assign bc[0] = b_center_x;
  assign bc[1] = b_center_y;
  assign bc[2] = b_center_z;
  assign ae[0] = a_extent_x;
  assign ae[1] = a_extent_y;
  assign ae[2] = a_extent_z;

  // Stage valid bits
  logic s1_valid, s2_valid, s3_valid, s4_valid, s5_valid, s6_valid;

  // Stage 1: box bounds and point (doubled units), center difference
  logic signed [EXT_W-1:0]  s1_lo   [AXES];
  logic signed [EXT_W-1:0]  s1_hi   [AXES];
  logic signed [EXT_W-1:0]  s1_p    [AXES];
  logic signed [DIFF_W-1:0] s1_diff [AXES];
  logic [LIM_W-1:0]         s1_lim;
  logic [1:0]               s1_op;

  // Stage 2: per-axis distance
  logic [GAP_W-1:0]         s2_gap  [AXES];
  logic [GAP_W-1:0]         s2_gap_next [AXES];
  logic [LIM_W-1:0]         s2_lim;
  logic [1:0]               s2_op;

  // Stage 3: partial products
  logic [2*DHI_W-1:0]       s3_hh [AXES];
  logic [DHI_W+DLO_W-1:0]   s3_hl [AXES];
  logic [2*DLO_W-1:0]       s3_ll [AXES];
  logic [2*LHI_W-1:0]       s3_lim_hh;
  logic [LHI_W+LLO_W-1:0]   s3_lim_hl;
  logic [2*LLO_W-1:0]       s3_lim_ll;
  logic                     s3_inside;
  logic [1:0]               s3_op;

  // Stage 4: assembled squares
  logic [SQ_W-1:0]          s4_sq [AXES];
  logic [LSQ_W-1:0]         s4_limsq;
  logic                     s4_inside;
  logic [1:0]               s4_op;

  // Stage 5: sum of squares
  logic [SUM_W-1:0]         s5_sum;
  logic [LSQ_W-1:0]         s5_limsq;
  logic                     s5_inside;
  logic [1:0]               s5_op;

  // Stage 6: result
  logic                     s6_hit;
  logic                     s6_hit_next;

  // Valid bits travel with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      s4_valid <= 1'b0;
      s5_valid <= 1'b0;
      s6_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= req_valid;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
      s4_valid <= s3_valid;
      s5_valid <= s4_valid;
      s6_valid <= s5_valid;
    end
  end

  // Stage 1 registers
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < AXES; i++) begin
        s1_lo[i]   <= (EXT_W'(ac[i]) <<< 1) - $signed(EXT_W'(ae[i]));
        s1_hi[i]   <= (EXT_W'(ac[i]) <<< 1) + $signed(EXT_W'(ae[i]));
        s1_p[i]    <= EXT_W'(bc[i]) <<< 1;
        s1_diff[i] <= DIFF_W'(ac[i]) - DIFF_W'(bc[i]);
      end
      if (operation == bvot_pkg::OP_BOX_SPHERE) begin
        s1_lim <= LIM_W'(b_radius) << 1;
      end else begin
        s1_lim <= LIM_W'(a_radius) + LIM_W'(b_radius);
      end
      s1_op <= operation;
    end
  end

  // Stage 2: clamp distance for box tests, absolute difference for spheres
  always_comb begin
    logic signed [EXT_W:0] below;
    logic signed [EXT_W:0] above;
    logic signed [DIFF_W-1:0] neg;
    for (int i = 0; i < AXES; i++) begin
      below = (EXT_W + 1)'(s1_lo[i]) - (EXT_W + 1)'(s1_p[i]);
      above = (EXT_W + 1)'(s1_p[i]) - (EXT_W + 1)'(s1_hi[i]);
      neg   = -s1_diff[i];
      if (s1_op == bvot_pkg::OP_SPHERE_SPHERE) begin
        if (s1_diff[i][DIFF_W-1]) begin
          s2_gap_next[i] = GAP_W'(unsigned'(neg));
        end else begin
          s2_gap_next[i] = GAP_W'(unsigned'(s1_diff[i]));
        end
      end else if (below > 0) begin
        s2_gap_next[i] = below[GAP_W-1:0];
      end else if (above > 0) begin
        s2_gap_next[i] = above[GAP_W-1:0];
      end else begin
        s2_gap_next[i] = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < AXES; i++) begin
        s2_gap[i] <= s2_gap_next[i];
      end
      s2_lim <= s1_lim;
      s2_op  <= s1_op;
    end
  end

  // Stage 3: split multiplies for the squares
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < AXES; i++) begin
        s3_hh[i] <= (2*DHI_W)'(s2_gap[i][GAP_W-1:DLO_W])
                  * (2*DHI_W)'(s2_gap[i][GAP_W-1:DLO_W]);
        s3_hl[i] <= (DHI_W+DLO_W)'(s2_gap[i][GAP_W-1:DLO_W])
                  * (DHI_W+DLO_W)'(s2_gap[i][DLO_W-1:0]);
        s3_ll[i] <= (2*DLO_W)'(s2_gap[i][DLO_W-1:0])
                  * (2*DLO_W)'(s2_gap[i][DLO_W-1:0]);
      end
      s3_lim_hh <= (2*LHI_W)'(s2_lim[LIM_W-1:LLO_W])
                 * (2*LHI_W)'(s2_lim[LIM_W-1:LLO_W]);
      s3_lim_hl <= (LHI_W+LLO_W)'(s2_lim[LIM_W-1:LLO_W])
                 * (LHI_W+LLO_W)'(s2_lim[LLO_W-1:0]);
      s3_lim_ll <= (2*LLO_W)'(s2_lim[LLO_W-1:0])
                 * (2*LLO_W)'(s2_lim[LLO_W-1:0]);
      // point lies in the box when every clamp distance is zero
      s3_inside <= (s2_gap[0] == '0) && (s2_gap[1] == '0) && (s2_gap[2] == '0);
      s3_op     <= s2_op;
    end
  end

  // Stage 4: assemble squares, hi^2 << 2L + 2*hi*lo << L + lo^2
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < AXES; i++) begin
        s4_sq[i] <= (SQ_W'(s3_hh[i]) << (2*DLO_W))
                  + (SQ_W'(s3_hl[i]) << (DLO_W + 1))
                  + SQ_W'(s3_ll[i]);
      end
      s4_limsq  <= (LSQ_W'(s3_lim_hh) << (2*LLO_W))
                 + (LSQ_W'(s3_lim_hl) << (LLO_W + 1))
                 + LSQ_W'(s3_lim_ll);
      s4_inside <= s3_inside;
      s4_op     <= s3_op;
    end
  end

  // Stage 5: sum of the three squares
  always_ff @(posedge clk) begin
    if (adv) begin
      s5_sum    <= SUM_W'(s4_sq[0]) + SUM_W'(s4_sq[1]) + SUM_W'(s4_sq[2]);
      s5_limsq  <= s4_limsq;
      s5_inside <= s4_inside;
      s5_op     <= s4_op;
    end
  end

  // Stage 6: pick the test result
  always_comb begin
    case (s5_op)
      bvot_pkg::OP_BOX_POINT:     s6_hit_next = s5_inside;
      bvot_pkg::OP_BOX_SPHERE:    s6_hit_next = (s5_sum <= SUM_W'(s5_limsq));
      bvot_pkg::OP_SPHERE_SPHERE: s6_hit_next = (s5_sum <= SUM_W'(s5_limsq));
      default:                    s6_hit_next = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s6_hit <= s6_hit_next;
    end
  end

  assign res_valid = s6_valid;
  assign hit       = s6_hit;

  // ------------------------------------------------------------------------
  // Assertions
  // ------------------------------------------------------------------------

  // A zero clamp distance on every axis must give a zero sum of squares
  a_inside_zero_sum: assert property (@(posedge clk) disable iff (rst)
    (s4_valid && adv && s4_inside) |=> (s5_sum == '0))
    else $error("inside flag set but sum of squares not zero");

  // While stalled, no stage valid bit moves
  a_stall_freezes: assert property (@(posedge clk) disable iff (rst)
    req_stall |=> $stable({s1_valid, s2_valid, s3_valid, s4_valid, s5_valid, s6_valid}))
    else $error("pipeline moved during stall");

  // A new result only comes from an occupied stage 5
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> $past(s5_valid))
    else $error("result appeared without a request behind it");

  // Reset empties the output
  a_reset_clears: assert property (@(posedge clk)
    rst |=> !res_valid)
    else $error("result valid right after reset");

endmodule

// ===== tb/bvot_hit_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bvot_hit_checker: hit predictor and scoreboard for the overlap test
// Watches both channels. Every accepted request gets its expected hit bit
// from an exact wide-integer model of the three overlap tests. Every accepted
// result is compared in order against the oldest expected bit.
// ----------------------------------------------------------------------------
module bvot_hit_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          req_valid,
  input  logic                          req_stall,
  input  logic [1:0]                    operation,
  input  logic [bvot_pkg::COORD_W-1:0]  a_center_x,
  input  logic [bvot_pkg::COORD_W-1:0]  a_center_y,
  input  logic [bvot_pkg::COORD_W-1:0]  a_center_z,
  input  logic [bvot_pkg::SIZE_W-1:0]   a_extent_x,
  input  logic [bvot_pkg::SIZE_W-1:0]   a_extent_y,
  input  logic [bvot_pkg::SIZE_W-1:0]   a_extent_z,
  input  logic [bvot_pkg::SIZE_W-1:0]   a_radius,
  input  logic [bvot_pkg::COORD_W-1:0]  b_center_x,
  input  logic [bvot_pkg::COORD_W-1:0]  b_center_y,
  input  logic [bvot_pkg::COORD_W-1:0]  b_center_z,
  input  logic [bvot_pkg::SIZE_W-1:0]   b_radius,
  input  logic                          res_valid,
  input  logic                          res_stall,
  input  logic                          hit,
  output int                            fail_count,
  output int                            pending,
  output int                            results_checked
);

  // Hit bits of accepted requests, oldest first
  logic hit_queue [$];
  int   errors  = 0;
  int   checked = 0;

  function automatic longint axis_gap(input longint p, input longint q);
    return (p >= q) ? p - q : q - p;
  endfunction

  // Gaps stay below 2^36, so the square fits easily in 128 bits
  function automatic logic [127:0] wide_square(input longint v);
    logic [127:0] w;
    w = v;
    return w * w;
  endfunction

  // Box tests work in doubled units so the half size is never rounded
  function automatic logic overlap_hit(
    input logic [1:0]                            op,
    input logic [2:0][bvot_pkg::COORD_W-1:0]     a_ctr,
    input logic [2:0][bvot_pkg::SIZE_W-1:0]      a_ext,
    input logic [bvot_pkg::SIZE_W-1:0]           a_rad,
    input logic [2:0][bvot_pkg::COORD_W-1:0]     b_ctr,
    input logic [bvot_pkg::SIZE_W-1:0]           b_rad
  );
    longint       ac, bc, ae, lo, hi, p, c;
    logic [127:0] dist_sq;
    logic         contained;
    int           k;
    dist_sq   = '0;
    contained = 1'b1;
    for (k = 0; k < bvot_pkg::AXES; k++) begin
      ac = $signed(a_ctr[k]);
      bc = $signed(b_ctr[k]);
      ae = a_ext[k];
      case (op)
        bvot_pkg::OP_BOX_POINT: begin
          if (2 * axis_gap(ac, bc) > ae) contained = 1'b0;
        end
        bvot_pkg::OP_BOX_SPHERE: begin
          p  = 2 * bc;
          lo = 2 * ac - ae;
          hi = 2 * ac + ae;
          c  = (p < lo) ? lo : ((p > hi) ? hi : p);
          dist_sq = dist_sq + wide_square(axis_gap(c, p));
        end
        default: begin
          dist_sq = dist_sq + wide_square(axis_gap(ac, bc));
        end
      endcase
    end
    case (op)
      bvot_pkg::OP_BOX_POINT:
        return contained;
      bvot_pkg::OP_BOX_SPHERE:
        return dist_sq <= wide_square(2 * longint'(b_rad));
      bvot_pkg::OP_SPHERE_SPHERE:
        return dist_sq <= wide_square(longint'(a_rad) + longint'(b_rad));
      default:
        return 1'b0;
    endcase
  endfunction

  // Compare results, then queue the prediction for a new request
  always @(posedge clk) begin : watch_channels
    logic want;
    if (!rst) begin
      if (res_valid && !res_stall) begin
        if (hit_queue.size() == 0) begin
          errors++;
          $display("%0t: result hit=%0b arrived with no request outstanding", $time, hit);
        end else begin
          want = hit_queue.pop_front();
          checked++;
          if (hit !== want) begin
            errors++;
            $display("%0t: hit mismatch, expected %0b, actual %0b", $time, want, hit);
          end
        end
      end
      if (req_valid && !req_stall)
        hit_queue.push_back(overlap_hit(operation,
                                        {a_center_z, a_center_y, a_center_x},
                                        {a_extent_z, a_extent_y, a_extent_x},
                                        a_radius,
                                        {b_center_z, b_center_y, b_center_x},
                                        b_radius));
      pending         <= hit_queue.size();
      fail_count      <= errors;
      results_checked <= checked;
    end
  end

endmodule

// ===== tb/bounding_volume_overlap_test_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bounding_volume_overlap_test_tb: stimulus and verdict for the overlap test
// Sends directed corner cases (touching, just missing, extreme coordinates,
// degenerate sizes, unused operation) and then random requests clustered
// around the hit boundary, with random gaps and result back-pressure.
// ----------------------------------------------------------------------------
module bounding_volume_overlap_test_tb;

  localparam logic [1:0]                   OP_UNUSED   = 2'd3;
  localparam int                           RAND_REQS   = 1030;
  localparam int                           DRAIN_AT    = 500;
  localparam int                           CYCLE_LIMIT = 200000;
  localparam logic [bvot_pkg::COORD_W-1:0] ONE         = 32'h0001_0000;
  localparam logic [bvot_pkg::COORD_W-1:0] CMIN        = 32'h8000_0000;
  localparam logic [bvot_pkg::COORD_W-1:0] CMAX        = 32'h7fff_ffff;
  localparam logic [bvot_pkg::COORD_W-1:0] SMAX        = 32'h7fff_ffff;

  typedef struct packed {
    logic [1:0]                           op;
    logic [2:0][bvot_pkg::COORD_W-1:0]    ac;
    logic [2:0][bvot_pkg::SIZE_W-1:0]     ae;
    logic [bvot_pkg::SIZE_W-1:0]          ar;
    logic [2:0][bvot_pkg::COORD_W-1:0]    bc;
    logic [bvot_pkg::SIZE_W-1:0]          br;
  } req_t;

  logic                                clk        = 1'b0;
  logic                                rst        = 1'b1;
  logic                                req_valid  = 1'b0;
  logic                                req_stall;
  logic [1:0]                          operation  = '0;
  logic signed [bvot_pkg::COORD_W-1:0] a_center_x = '0;
  logic signed [bvot_pkg::COORD_W-1:0] a_center_y = '0;
  logic signed [bvot_pkg::COORD_W-1:0] a_center_z = '0;
  logic [bvot_pkg::SIZE_W-1:0]         a_extent_x = '0;
  logic [bvot_pkg::SIZE_W-1:0]         a_extent_y = '0;
  logic [bvot_pkg::SIZE_W-1:0]         a_extent_z = '0;
  logic [bvot_pkg::SIZE_W-1:0]         a_radius   = '0;
  logic signed [bvot_pkg::COORD_W-1:0] b_center_x = '0;
  logic signed [bvot_pkg::COORD_W-1:0] b_center_y = '0;
  logic signed [bvot_pkg::COORD_W-1:0] b_center_z = '0;
  logic [bvot_pkg::SIZE_W-1:0]         b_radius   = '0;
  logic                                res_valid;
  logic                                res_stall  = 1'b0;
  logic                                hit;

  int   fail_count;
  int   pending;
  int   results_checked;
  int   cycle_count = 0;
  int   op_count [4];
  logic calm = 1'b0;
  req_t directed [$];

  bounding_volume_overlap_test i_dut (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_stall  (req_stall),
    .operation  (operation),
    .a_center_x (a_center_x),
    .a_center_y (a_center_y),
    .a_center_z (a_center_z),
    .a_extent_x (a_extent_x),
    .a_extent_y (a_extent_y),
    .a_extent_z (a_extent_z),
    .a_radius   (a_radius),
    .b_center_x (b_center_x),
    .b_center_y (b_center_y),
    .b_center_z (b_center_z),
    .b_radius   (b_radius),
    .res_valid  (res_valid),
    .res_stall  (res_stall),
    .hit        (hit)
  );

  bvot_hit_checker i_checker (
    .clk             (clk),
    .rst             (rst),
    .req_valid       (req_valid),
    .req_stall       (req_stall),
    .operation       (operation),
    .a_center_x      (a_center_x),
    .a_center_y      (a_center_y),
    .a_center_z      (a_center_z),
    .a_extent_x      (a_extent_x),
    .a_extent_y      (a_extent_y),
    .a_extent_z      (a_extent_z),
    .a_radius        (a_radius),
    .b_center_x      (b_center_x),
    .b_center_y      (b_center_y),
    .b_center_z      (b_center_z),
    .b_radius        (b_radius),
    .res_valid       (res_valid),
    .res_stall       (res_stall),
    .hit             (hit),
    .fail_count      (fail_count),
    .pending         (pending),
    .results_checked (results_checked)
  );

  // 100 MHz clock
  initial begin
    forever #5 clk = ~clk;
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Sizes and radii keep their low SIZE_W bits, as on the ports
  function automatic req_t overlap_req(
    input logic [1:0]                   op,
    input logic [bvot_pkg::COORD_W-1:0] ax, ay, az,
    input logic [bvot_pkg::COORD_W-1:0] ex, ey, ez, ar,
    input logic [bvot_pkg::COORD_W-1:0] bx, by, bz,
    input logic [bvot_pkg::COORD_W-1:0] br
  );
    req_t r;
    r.op = op;
    r.ac = {az, ay, ax};
    r.ae = {ez[bvot_pkg::SIZE_W-1:0], ey[bvot_pkg::SIZE_W-1:0],
            ex[bvot_pkg::SIZE_W-1:0]};
    r.ar = ar[bvot_pkg::SIZE_W-1:0];
    r.bc = {bz, by, bx};
    r.br = br[bvot_pkg::SIZE_W-1:0];
    return r;
  endfunction

  // Random request: mostly centers placed near the hit boundary of the
  // chosen test, sometimes fully random fields
  function automatic req_t rand_req();
    req_t         r;
    logic [31:0]  mask;
    longint       span, m;
    int           k;
    r.op = ($urandom_range(0, 15) == 0) ? OP_UNUSED : 2'($urandom_range(0, 2));
    if ($urandom_range(0, 4) == 0) begin
      for (k = 0; k < bvot_pkg::AXES; k++) begin
        r.ac[k] = $urandom;
        r.ae[k] = bvot_pkg::SIZE_W'($urandom);
        r.bc[k] = $urandom;
      end
      r.ar = bvot_pkg::SIZE_W'($urandom);
      r.br = bvot_pkg::SIZE_W'($urandom);
    end else begin
      mask = (32'd1 << $urandom_range(1, 30)) - 32'd1;
      r.ar = bvot_pkg::SIZE_W'($urandom & mask);
      r.br = bvot_pkg::SIZE_W'($urandom & mask);
      for (k = 0; k < bvot_pkg::AXES; k++) begin
        r.ac[k] = $urandom;
        r.ae[k] = bvot_pkg::SIZE_W'($urandom & mask);
        // span/2 is the reach along this axis before the test fails
        case (r.op)
          bvot_pkg::OP_BOX_POINT:  span = longint'(r.ae[k]);
          bvot_pkg::OP_BOX_SPHERE: span = longint'(r.ae[k]) + 2 * longint'(r.br);
          default:                 span = 2 * (longint'(r.ar) + longint'(r.br));
        endcase
        case ($urandom_range(0, 3))
          0:       m = $urandom_range(0, 32'(span / 2));
          1:       m = span / 2;
          2:       m = $urandom_range(0, 32'(span));
          default: m = span / 2 + 1;
        endcase
        if ($urandom_range(0, 1) == 1) m = -m;
        r.bc[k] = r.ac[k] + 32'(m);
      end
    end
    return r;
  endfunction

  // Drive one request after a random gap, hold it until accepted
  task automatic send_req(input req_t r);
    int n;
    n = calm ? 0 : $urandom_range(0, 4);
    repeat (n) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid  <= 1'b1;
    operation  <= r.op;
    a_center_x <= r.ac[0];
    a_center_y <= r.ac[1];
    a_center_z <= r.ac[2];
    a_extent_x <= r.ae[0];
    a_extent_y <= r.ae[1];
    a_extent_z <= r.ae[2];
    a_radius   <= r.ar;
    b_center_x <= r.bc[0];
    b_center_y <= r.bc[1];
    b_center_z <= r.bc[2];
    b_radius   <= r.br;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    op_count[r.op]++;
  endtask

  // Result side: random stall before each result
  initial begin : result_sink
    int n;
    @(posedge clk iff !rst);
    forever begin
      n = calm ? 0 : $urandom_range(0, 4);
      repeat (n) begin
        res_stall <= 1'b1;
        @(posedge clk);
      end
      res_stall <= 1'b0;
      @(posedge clk);
      while (!(res_valid && !res_stall)) @(posedge clk);
    end
  end

  // Stimulus and verdict
  initial begin
    int k;
    foreach (op_count[k]) op_count[k] = 0;

    // Box against point: degenerate box, touching face, just past it,
    // extreme opposite corners, odd extent
    directed.push_back(overlap_req(bvot_pkg::OP_BOX_POINT,
                                   0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    directed.push_back(overlap_req(bvot_pkg::OP_BOX_POINT, 0, 0, 0, 2 * ONE, 0, 0, 0,
                                   ONE, 0, 0, 0));
    directed.push_back(overlap_req(bvot_pkg::OP_BOX_POINT, 0, 0, 0, 2 * ONE, 0, 0, 0,
                                   ONE + 1, 0, 0, 0));
    directed.push_back(overlap_req(bvot_pkg::OP_BOX_POINT, CMIN, CMIN, CMIN,
                                   SMAX, SMAX, SMAX, SMAX,
                                   CMAX, CMAX, CMAX, SMAX));
    directed.push_back(overlap_req(bvot_pkg::OP_BOX_POINT, CMAX, CMAX, CMAX, 0, 0, 0, 0,
                                   CMAX, CMAX, CMAX, 0));
    directed.push_back(overlap_req(bvot_pkg::OP_BOX_POINT, -ONE, 0, 0, 3, 3, 3, 0,
                                   -ONE + 1, 0, 0, 0));
    directed.push_back(overlap_req(bvot_pkg::OP_BOX_POINT, -ONE, 0, 0, 3, 3, 3, 0,
                                   -ONE - 2, 0, 0, 0));
    // Box against sphere: touching face, missing face, corner hit and miss,
    // zero-radius sphere inside, extremes
    directed.push_back(overlap_req(bvot_pkg::OP_BOX_SPHERE, 0, 0, 0,
                                   2 * ONE, 2 * ONE, 2 * ONE, 0,
                                   4 * ONE, 0, 0, 3 * ONE));
    directed.push_back(overlap_req(bvot_pkg::OP_BOX_SPHERE, 0, 0, 0,
                                   2 * ONE, 2 * ONE, 2 * ONE, 0,
                                   4 * ONE, 0, 0, 2 * ONE));
    directed.push_back(overlap_req(bvot_pkg::OP_BOX_SPHERE, 0, 0, 0, 2, 2, 2, 0,
                                   4, -4, 0, 5));
    directed.push_back(overlap_req(bvot_pkg::OP_BOX_SPHERE, 0, 0, 0, 2, 2, 2, 0,
                                   4, -4, 0, 4));
    directed.push_back(overlap_req(bvot_pkg::OP_BOX_SPHERE, ONE, ONE, ONE, 2, 2, 2, 0,
                                   ONE, ONE, ONE, 0));
    directed.push_back(overlap_req(bvot_pkg::OP_BOX_SPHERE, CMIN, CMIN, CMIN,
                                   SMAX, SMAX, SMAX, SMAX,
                                   CMAX, CMAX, CMAX, SMAX));
    directed.push_back(overlap_req(bvot_pkg::OP_BOX_SPHERE, CMAX, CMAX, CMAX,
                                   SMAX, SMAX, SMAX, 0,
                                   CMAX, CMAX, CMAX, 0));
    // Sphere against sphere: touching, apart, 3-4-5 diagonal, extremes
    directed.push_back(overlap_req(bvot_pkg::OP_SPHERE_SPHERE, 0, 0, 0, 0, 0, 0, 2 * ONE,
                                   5 * ONE, 0, 0, 3 * ONE));
    directed.push_back(overlap_req(bvot_pkg::OP_SPHERE_SPHERE, 0, 0, 0, 0, 0, 0, 2 * ONE,
                                   6 * ONE, 0, 0, 3 * ONE));
    directed.push_back(overlap_req(bvot_pkg::OP_SPHERE_SPHERE, 0, 0, 0, 0, 0, 0, 5,
                                   3, -4, 0, 0));
    directed.push_back(overlap_req(bvot_pkg::OP_SPHERE_SPHERE, 0, 0, 0, 0, 0, 0, 5,
                                   3, -4, 1, 0));
    directed.push_back(overlap_req(bvot_pkg::OP_SPHERE_SPHERE, CMIN, CMIN, CMIN,
                                   0, 0, 0, SMAX,
                                   CMAX, CMAX, CMAX, SMAX));
    directed.push_back(overlap_req(bvot_pkg::OP_SPHERE_SPHERE, CMIN, CMIN, CMIN,
                                   0, 0, 0, 0,
                                   CMIN, CMIN, CMIN, 0));
    directed.push_back(overlap_req(bvot_pkg::OP_SPHERE_SPHERE, CMIN, 0, 0, 0, 0, 0, SMAX,
                                   CMAX, 0, 0, SMAX));
    directed.push_back(overlap_req(bvot_pkg::OP_SPHERE_SPHERE, CMIN, 0, 0, 0, 0, 0, SMAX,
                                   CMAX - 1, 0, 0, SMAX));
    // Unused operation never hits
    directed.push_back(overlap_req(OP_UNUSED, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    directed.push_back(overlap_req(OP_UNUSED, CMAX, CMAX, CMAX, SMAX, SMAX, SMAX, SMAX,
                                   CMAX, CMAX, CMAX, SMAX));

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed[k]) send_req(directed[k]);

    for (k = 0; k < RAND_REQS; k++) begin
      if (k % 150 == 0) calm = ($urandom_range(0, 3) == 0);
      // Let the pipeline run dry once mid-stream
      if (k == DRAIN_AT) begin
        req_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
      end
      send_req(rand_req());
    end
    req_valid <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (12) @(posedge clk);

    $display("Sent %0d box/point, %0d box/sphere, %0d sphere/sphere, %0d unused-op requests",
             op_count[bvot_pkg::OP_BOX_POINT], op_count[bvot_pkg::OP_BOX_SPHERE],
             op_count[bvot_pkg::OP_SPHERE_SPHERE], op_count[OP_UNUSED]);
    $display("%0d hit results compared, %0d still outstanding", results_checked, pending);
    if (fail_count == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/bvot_pkg.sv
design/bounding_volume_overlap_test.sv
tb/bvot_hit_checker.sv
tb/bounding_volume_overlap_test_tb.sv
